>>> hw/rtl/slt_pkg.sv
`default_nettype none
package slt_pkg;

  localparam int CMD_W = 3;
  localparam int POS_W = 7;
  localparam int IO_VAL_W = 32;
  localparam int CNT_OUT_W = 7;

  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DROP_NEG = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DROP_EVEN = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ = 3'd5;

  typedef struct packed {
    logic                 ok;
    logic [IO_VAL_W-1:0]  read_value;
    logic [CNT_OUT_W-1:0] count;
    logic                 empty_res;
    logic                 full_res;
  } res_t;

endpackage
`default_nettype wire

>>> hw/rtl/sorted_list_table.sv
// Sorted list table: up to DEPTH signed words kept largest first, plus a count.
// Input channel (in_valid/in_stall) takes one command item: insert, remove value,
// remove negatives, remove evens, clear or read at a 1-based position.
// Every item yields exactly one result item on the out_ channel: ok, read value,
// and count/empty/full as they stand after the command.
// Work per item before its result goes to the out_ registers:
//   clear, unknown codes, read out of range, insert when full or into an empty
//   table, remove or filter on an empty table: result formed when the item is accepted
//   read in range: one RAM read
//   insert: walks down from the tail until the slot is found
//   remove value and filters: one full pass over the entries
// The entries sit in one single-port-write, registered-read RAM; the pass is bound
// by one read and one write per cycle, as the RAM has one port for each.
// One item is worked on at a time; in_stall is high while it is in flight. With
// out_stall low the next item is taken in the cycle after the out_ registers load.
// The result register frees the engine: the next item is taken while a result
// still waits on out_stall, and the engine holds its next result until the
// register is taken. Reset empties the table; RAM contents need no clearing.
`default_nettype none
module sorted_list_table #(
  parameter int DEPTH = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    in_valid,
  output logic                                         in_stall,
  input  wire logic [slt_pkg::CMD_W-1:0]               in_cmd,
  input  wire logic signed [slt_pkg::IO_VAL_W-1:0]     in_value,
  input  wire logic [slt_pkg::POS_W-1:0]               in_position,
  output logic                                         out_valid,
  input  wire logic                                    out_stall,
  output logic                                         out_ok,
  output logic signed [slt_pkg::IO_VAL_W-1:0]          out_read_value,
  output logic [slt_pkg::CNT_OUT_W-1:0]                out_count,
  output logic                                         out_empty_res,
  output logic                                         out_full_res
);

  logic                          start, busy, res_valid, res_ready;
  slt_pkg::res_t                 res;
  slt_pkg::res_t                 out_r;
  logic                          out_valid_r, out_valid_nxt;
  logic [VALUE_WIDTH+31:0]       val_sext;
  logic signed [VALUE_WIDTH-1:0] val;

  // input value taken as VALUE_WIDTH bits, sign-extended when wider
  assign val_sext = {{VALUE_WIDTH{in_value[slt_pkg::IO_VAL_W-1]}}, in_value};
  assign val = val_sext[VALUE_WIDTH-1:0];

  assign in_stall = busy;
  assign start = in_valid && !busy;
  assign res_ready = !out_valid_r || !out_stall;

  slt_engine #(
    .DEPTH(DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .cmd      (in_cmd),
    .val      (val),
    .pos      (in_position),
    .busy     (busy),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_ok = out_r.ok;
  assign out_read_value = out_r.read_value;
  assign out_count = out_r.count;
  assign out_empty_res = out_r.empty_res;
  assign out_full_res = out_r.full_res;

`ifndef SYNTHESIS
  // every accepted item occupies the engine at least until its result is formed
  assert property (@(posedge clk) disable iff (!rst_n) start |=> busy)
    else $error("engine idle right after accepting an item");

  // a failed command never carries a read value
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_read_value == '0))
    else $error("nonzero read value on a failed command");

  // a pending result is only offered while the input side is held off
  assert property (@(posedge clk) disable iff (!rst_n) res_valid |-> in_stall)
    else $error("result pending while input accepted");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/slt_ram.sv
`default_nettype none
module slt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/slt_engine.sv
`default_nettype none
module slt_engine #(
  parameter int DEPTH = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [slt_pkg::CMD_W-1:0]     cmd,
  input  wire logic signed [VALUE_WIDTH-1:0] val,
  input  wire logic [slt_pkg::POS_W-1:0]     pos,
  output logic                               busy,
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output slt_pkg::res_t                      res
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = CW + slt_pkg::POS_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_FIN  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [slt_pkg::CMD_W-1:0]     cmd_r, cmd_nxt;
  logic [VALUE_WIDTH-1:0]        val_r, val_nxt;
  logic [CW-1:0]                 count_r, count_nxt;
  logic [AW-1:0]                 rptr_r, rptr_nxt;
  logic [CW-1:0]                 left_r, left_nxt;
  logic                          pv_r, pv_nxt;
  logic [AW-1:0]                 kidx_r, kidx_nxt;
  logic [CW-1:0]                 w_r, w_nxt;
  logic                          dropped_r, dropped_nxt;
  slt_pkg::res_t                 res_r, res_nxt;

  logic                          rd_en, wr_en;
  logic [AW-1:0]                 rd_addr, wr_addr;
  logic [VALUE_WIDTH-1:0]        wr_data, rd_data;

  logic                          fin, fin_ok;
  logic [CW-1:0]                 fin_cnt;
  logic [slt_pkg::IO_VAL_W-1:0]  fin_rd;
  logic                          drop;

  logic [PW-1:0]                 pos_ext, cnt_ext, pos_m1;
  logic [CW-1:0]                 cnt_m1;
  logic [VALUE_WIDTH+31:0]       rd_sext;
  logic [CW+6:0]                 fin_cnt_ext;

  assign pos_ext = {{CW{1'b0}}, pos};
  assign cnt_ext = {{slt_pkg::POS_W{1'b0}}, count_r};
  assign pos_m1 = pos_ext - PW'(1);
  assign cnt_m1 = count_r - CW'(1);
  assign rd_sext = {{32{rd_data[VALUE_WIDTH-1]}}, rd_data};
  assign fin_cnt_ext = {7'b0, fin_cnt};

  slt_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_comb begin
    case (cmd_r)
      slt_pkg::CMD_DROP_NEG:  drop = rd_data[VALUE_WIDTH-1];
      slt_pkg::CMD_DROP_EVEN: drop = !rd_data[0];
      default:                drop = !dropped_r && (rd_data == val_r);
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    cmd_nxt = cmd_r;
    val_nxt = val_r;
    count_nxt = count_r;
    rptr_nxt = rptr_r;
    left_nxt = left_r;
    pv_nxt = 1'b0;
    kidx_nxt = kidx_r;
    w_nxt = w_r;
    dropped_nxt = dropped_r;
    res_nxt = res_r;
    rd_en = 1'b0;
    rd_addr = rptr_r;
    wr_en = 1'b0;
    wr_addr = kidx_r;
    wr_data = val_r;
    fin = 1'b0;
    fin_ok = 1'b0;
    fin_cnt = count_r;
    fin_rd = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt = cmd;
          val_nxt = val;
          w_nxt = '0;
          dropped_nxt = 1'b0;
          case (cmd)
            slt_pkg::CMD_INSERT: begin
              if (count_r == CW'(DEPTH)) begin
                fin = 1'b1;
              end else if (count_r == '0) begin
                wr_en = 1'b1;
                wr_addr = '0;
                wr_data = val;
                fin = 1'b1;
                fin_ok = 1'b1;
                fin_cnt = CW'(1);
              end else begin
                rptr_nxt = cnt_m1[AW-1:0];
                left_nxt = count_r;
                state_nxt = S_SCAN;
              end
            end
            slt_pkg::CMD_REMOVE, slt_pkg::CMD_DROP_NEG, slt_pkg::CMD_DROP_EVEN: begin
              if (count_r == '0) begin
                fin = 1'b1;
              end else begin
                rptr_nxt = '0;
                left_nxt = count_r;
                state_nxt = S_SCAN;
              end
            end
            slt_pkg::CMD_CLEAR: begin
              fin = 1'b1;
              fin_ok = 1'b1;
              fin_cnt = '0;
            end
            slt_pkg::CMD_READ: begin
              if (pos != '0 && pos_ext <= cnt_ext) begin
                rptr_nxt = pos_m1[AW-1:0];
                left_nxt = CW'(1);
                state_nxt = S_SCAN;
              end else begin
                fin = 1'b1;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        // one read issued per cycle, data for the previous index processed
        if (left_r != '0) begin
          rd_en = 1'b1;
          pv_nxt = 1'b1;
          kidx_nxt = rptr_r;
          left_nxt = left_r - CW'(1);
          rptr_nxt = (cmd_r == slt_pkg::CMD_INSERT) ? rptr_r - AW'(1) : rptr_r + AW'(1);
        end
        if (pv_r) begin
          case (cmd_r)
            slt_pkg::CMD_INSERT: begin
              // backward walk: shift smaller entries up one slot
              wr_en = 1'b1;
              wr_addr = kidx_r + AW'(1);
              if ($signed(rd_data) < $signed(val_r)) begin
                wr_data = rd_data;
                if (kidx_r == '0) begin
                  state_nxt = S_FIN;
                  left_nxt = '0;
                end
              end else begin
                wr_data = val_r;
                fin = 1'b1;
                fin_ok = 1'b1;
                fin_cnt = count_r + CW'(1);
              end
            end
            slt_pkg::CMD_READ: begin
              fin = 1'b1;
              fin_ok = 1'b1;
              fin_rd = rd_sext[31:0];
            end
            default: begin
              // compaction: kept entries move down to the write pointer
              if (drop) begin
                dropped_nxt = 1'b1;
              end else begin
                wr_en = 1'b1;
                wr_addr = w_r[AW-1:0];
                wr_data = rd_data;
                w_nxt = w_r + CW'(1);
              end
              if (left_r == '0) begin
                fin = 1'b1;
                fin_ok = (w_nxt != count_r);
                fin_cnt = w_nxt;
              end
            end
          endcase
        end
      end
      S_FIN: begin
        wr_en = 1'b1;
        wr_addr = '0;
        wr_data = val_r;
        fin = 1'b1;
        fin_ok = 1'b1;
        fin_cnt = count_r + CW'(1);
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin) begin
      count_nxt = fin_cnt;
      res_nxt.ok = fin_ok;
      res_nxt.read_value = fin_rd;
      res_nxt.count = fin_cnt_ext[slt_pkg::CNT_OUT_W-1:0];
      res_nxt.empty_res = (fin_cnt == '0);
      res_nxt.full_res = (fin_cnt == CW'(DEPTH));
      left_nxt = '0;
      pv_nxt = 1'b0;
      state_nxt = S_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      left_r <= '0;
      pv_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      left_r <= left_nxt;
      pv_r <= pv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    val_r <= val_nxt;
    rptr_r <= rptr_nxt;
    kidx_r <= kidx_nxt;
    w_r <= w_nxt;
    dropped_r <= dropped_nxt;
    res_r <= res_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res = res_r;

endmodule
`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  localparam int DEPTH = 64;
  localparam logic [slt_pkg::CMD_W-1:0] CMD_BAD6 = 3'd6;
  localparam logic [slt_pkg::CMD_W-1:0] CMD_BAD7 = 3'd7;
  localparam int MODE_FILL = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIXED = 2;
  localparam int RAND_ITEMS = 1720;
  localparam int HOLD_AT = 500;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LO = 1000;
  localparam int QUIET_HI = 1300;
  localparam int DRAIN_CYCLES = 100;

  typedef struct {
    logic [slt_pkg::CMD_W-1:0]           cmd;
    logic signed [slt_pkg::IO_VAL_W-1:0] value;
    logic [slt_pkg::POS_W-1:0]           pos;
    bit                                  typed;
    slt_pkg::res_t                       want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [slt_pkg::CMD_W-1:0] in_cmd = '0;
  logic signed [slt_pkg::IO_VAL_W-1:0] in_value = '0;
  logic [slt_pkg::POS_W-1:0] in_position = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_ok;
  logic signed [slt_pkg::IO_VAL_W-1:0] out_read_value;
  logic [slt_pkg::CNT_OUT_W-1:0] out_count;
  logic out_empty_res;
  logic out_full_res;

  // shadow copy of the table, updated as each item is accepted
  logic signed [slt_pkg::IO_VAL_W-1:0] shadow [DEPTH];
  int shadow_cnt = 0;
  slt_pkg::res_t cmd_status_q [$];
  stim_row_t plan [$];
  int n_sent = 0;
  int n_rand = 0;
  int n_err = 0;
  logic quiet;

  assign quiet = (n_sent >= QUIET_LO) && (n_sent < QUIET_HI);

  always #4 clk = ~clk;

  sorted_list_table #(
    .DEPTH(DEPTH),
    .VALUE_WIDTH(slt_pkg::IO_VAL_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_cmd(in_cmd),
    .in_value(in_value),
    .in_position(in_position),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_ok(out_ok),
    .out_read_value(out_read_value),
    .out_count(out_count),
    .out_empty_res(out_empty_res),
    .out_full_res(out_full_res)
  );

  function automatic slt_pkg::res_t fixed_res(int ok, int rd, int cnt);
    slt_pkg::res_t r;
    r.ok = 1'(ok);
    r.read_value = slt_pkg::IO_VAL_W'(rd);
    r.count = slt_pkg::CNT_OUT_W'(cnt);
    r.empty_res = (cnt == 0);
    r.full_res = (cnt == DEPTH);
    return r;
  endfunction

  function automatic slt_pkg::res_t table_apply(logic [slt_pkg::CMD_W-1:0] cmd,
                                                logic signed [slt_pkg::IO_VAL_W-1:0] v,
                                                logic [slt_pkg::POS_W-1:0] pos);
    slt_pkg::res_t r;
    int i;
    int w;
    logic drop;
    r = '0;
    case (cmd)
      slt_pkg::CMD_INSERT: begin
        if (shadow_cnt < DEPTH) begin
          // equal entries stay ahead of the new value
          i = shadow_cnt;
          while (i > 0 && shadow[i-1] < v) begin
            shadow[i] = shadow[i-1];
            i--;
          end
          shadow[i] = v;
          shadow_cnt++;
          r.ok = 1'b1;
        end
      end
      slt_pkg::CMD_REMOVE: begin
        i = 0;
        while (i < shadow_cnt && shadow[i] > v) i++;
        if (i < shadow_cnt && shadow[i] == v) begin
          for (; i + 1 < shadow_cnt; i++) shadow[i] = shadow[i+1];
          shadow_cnt--;
          r.ok = 1'b1;
        end
      end
      slt_pkg::CMD_DROP_NEG, slt_pkg::CMD_DROP_EVEN: begin
        w = 0;
        for (i = 0; i < shadow_cnt; i++) begin
          drop = (cmd == slt_pkg::CMD_DROP_NEG) ? shadow[i][slt_pkg::IO_VAL_W-1]
                                                 : !shadow[i][0];
          if (!drop) begin
            shadow[w] = shadow[i];
            w++;
          end
        end
        r.ok = (w != shadow_cnt);
        shadow_cnt = w;
      end
      slt_pkg::CMD_CLEAR: begin
        shadow_cnt = 0;
        r.ok = 1'b1;
      end
      slt_pkg::CMD_READ: begin
        if (pos >= 1 && pos <= shadow_cnt) begin
          r.ok = 1'b1;
          r.read_value = shadow[pos-1];
        end
      end
      default: ;
    endcase
    r.count = slt_pkg::CNT_OUT_W'(shadow_cnt);
    r.empty_res = (shadow_cnt == 0);
    r.full_res = (shadow_cnt == DEPTH);
    return r;
  endfunction

  function automatic logic [slt_pkg::CMD_W-1:0] pick_cmd(int mode);
    int w [7];
    int roll;
    int k;
    logic [slt_pkg::CMD_W-1:0] codes [6];
    codes = '{slt_pkg::CMD_INSERT, slt_pkg::CMD_REMOVE, slt_pkg::CMD_DROP_NEG,
              slt_pkg::CMD_DROP_EVEN, slt_pkg::CMD_CLEAR, slt_pkg::CMD_READ};
    case (mode)
      MODE_FILL:  w = '{70, 8, 2, 2, 1, 14, 3};
      MODE_DRAIN: w = '{8, 52, 8, 8, 2, 16, 6};
      default:    w = '{34, 30, 5, 5, 2, 20, 4};
    endcase
    roll = $urandom_range(99);
    for (k = 0; k < 6; k++) begin
      if (roll < w[k]) break;
      roll -= w[k];
    end
    if (k == 6) return $urandom_range(1) ? CMD_BAD6 : CMD_BAD7;
    return codes[k];
  endfunction

  function automatic logic signed [slt_pkg::IO_VAL_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(9);
    if (sel < 4) return $urandom;
    // narrow range: duplicates, evens and negatives
    if (sel < 7) return int'($urandom_range(16)) - 8;
    if (sel < 8 && shadow_cnt > 0) return shadow[$urandom_range(shadow_cnt - 1)];
    return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
  endfunction

  task automatic send_item(input logic [slt_pkg::CMD_W-1:0] cmd,
                           input logic signed [slt_pkg::IO_VAL_W-1:0] v,
                           input logic [slt_pkg::POS_W-1:0] pos, input bit typed,
                           input slt_pkg::res_t want);
    slt_pkg::res_t pred;
    while (!quiet && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_value <= v;
    in_position <= pos;
    do @(posedge clk); while (in_stall);
    pred = table_apply(cmd, v, pos);
    cmd_status_q.push_back(typed ? want : pred);
    n_sent++;
  endtask

  initial begin
    int k;
    int seg_len;
    int mode;
    logic [slt_pkg::CMD_W-1:0] c;
    logic signed [slt_pkg::IO_VAL_W-1:0] v;
    logic [slt_pkg::POS_W-1:0] p;

    plan.push_back(stim_row_t'{slt_pkg::CMD_READ, 0, 7'd0, 1'b1, fixed_res(0, 0, 0)});
    plan.push_back(stim_row_t'{slt_pkg::CMD_READ, 0, 7'd1, 1'b1, fixed_res(0, 0, 0)});
    plan.push_back(stim_row_t'{slt_pkg::CMD_REMOVE, 5, 7'd0, 1'b1, fixed_res(0, 0, 0)});
    plan.push_back(stim_row_t'{slt_pkg::CMD_DROP_NEG, 0, 7'd0, 1'b1, fixed_res(0, 0, 0)});
    plan.push_back(stim_row_t'{slt_pkg::CMD_DROP_EVEN, 0, 7'd0, 1'b1, fixed_res(0, 0, 0)});
    plan.push_back(stim_row_t'{slt_pkg::CMD_CLEAR, 0, 7'd0, 1'b1, fixed_res(1, 0, 0)});
    plan.push_back(stim_row_t'{CMD_BAD6, 0, 7'd0, 1'b1, fixed_res(0, 0, 0)});
    plan.push_back(stim_row_t'{slt_pkg::CMD_INSERT, 32'sh7fff_ffff, 7'd0, 1'b1,
                               fixed_res(1, 0, 1)});
    plan.push_back(stim_row_t'{slt_pkg::CMD_INSERT, 32'sh8000_0000, 7'd0, 1'b1,
                               fixed_res(1, 0, 2)});
    plan.push_back(stim_row_t'{slt_pkg::CMD_INSERT, 0, 7'd0, 1'b1, fixed_res(1, 0, 3)});
    plan.push_back(stim_row_t'{slt_pkg::CMD_INSERT, 0, 7'd0, 1'b1, fixed_res(1, 0, 4)});
    plan.push_back(stim_row_t'{slt_pkg::CMD_INSERT, -2, 7'd0, 1'b1, fixed_res(1, 0, 5)});
    plan.push_back(stim_row_t'{slt_pkg::CMD_INSERT, 7, 7'd0, 1'b1, fixed_res(1, 0, 6)});
    plan.push_back(stim_row_t'{slt_pkg::CMD_READ, 0, 7'd1, 1'b1,
                               fixed_res(1, 32'h7fff_ffff, 6)});
    plan.push_back(stim_row_t'{slt_pkg::CMD_READ, 0, 7'd6, 1'b1,
                               fixed_res(1, 32'h8000_0000, 6)});
    plan.push_back(stim_row_t'{slt_pkg::CMD_READ, 0, 7'd7, 1'b1, fixed_res(0, 0, 6)});
    plan.push_back(stim_row_t'{slt_pkg::CMD_READ, 0, 7'd127, 1'b1, fixed_res(0, 0, 6)});
    plan.push_back(stim_row_t'{CMD_BAD7, -1, 7'd3, 1'b1, fixed_res(0, 0, 6)});
    plan.push_back(stim_row_t'{slt_pkg::CMD_REMOVE, 5, 7'd0, 1'b1, fixed_res(0, 0, 6)});
    plan.push_back(stim_row_t'{slt_pkg::CMD_REMOVE, 0, 7'd0, 1'b0, '0});
    plan.push_back(stim_row_t'{slt_pkg::CMD_READ, 0, 7'd3, 1'b0, '0});
    // even filter takes the minimum word too
    plan.push_back(stim_row_t'{slt_pkg::CMD_DROP_EVEN, 0, 7'd0, 1'b0, '0});
    plan.push_back(stim_row_t'{slt_pkg::CMD_DROP_NEG, 0, 7'd0, 1'b0, '0});
    plan.push_back(stim_row_t'{slt_pkg::CMD_INSERT, -1, 7'd0, 1'b0, '0});
    plan.push_back(stim_row_t'{slt_pkg::CMD_DROP_NEG, 0, 7'd0, 1'b0, '0});
    plan.push_back(stim_row_t'{slt_pkg::CMD_CLEAR, 0, 7'd0, 1'b1, fixed_res(1, 0, 0)});

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) send_item(plan[i].cmd, plan[i].value, plan[i].pos, plan[i].typed,
                                plan[i].want);

    // segments that lean toward filling or draining so both full and empty get hit
    while (n_rand < RAND_ITEMS) begin
      mode = $urandom_range(MODE_MIXED);
      seg_len = $urandom_range(20, 120);
      for (k = 0; k < seg_len && n_rand < RAND_ITEMS; k++) begin
        c = pick_cmd(mode);
        v = pick_value();
        p = slt_pkg::POS_W'($urandom_range(127));
        if (c == slt_pkg::CMD_REMOVE && shadow_cnt > 0 && $urandom_range(3) != 0)
          v = shadow[$urandom_range(shadow_cnt - 1)];
        if (c == slt_pkg::CMD_READ && $urandom_range(4) != 0)
          p = slt_pkg::POS_W'($urandom_range(shadow_cnt + 1));
        send_item(c, v, p, 1'b0, '0);
        n_rand++;
      end
    end
    in_valid <= 1'b0;

    while (cmd_status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_err == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // result side: random stall, one long hold-off so the block backs up
  initial begin : rx_side
    int held_for;
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && n_sent >= HOLD_AT) begin
        held = 1'b1;
        out_stall <= 1'b1;
        for (held_for = 0; held_for < HOLD_CYCLES; held_for++) @(posedge clk);
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 13);
      end
    end
  end

  always @(posedge clk) begin
    slt_pkg::res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (cmd_status_q.size() == 0) begin
        $error("result item with no command outstanding");
        n_err++;
      end else begin
        want = cmd_status_q.pop_front();
        if (out_ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, out_ok);
          n_err++;
        end
        if (out_read_value !== want.read_value) begin
          $error("read_value: expected %h, got %h", want.read_value, out_read_value);
          n_err++;
        end
        if (out_count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, out_count);
          n_err++;
        end
        if (out_empty_res !== want.empty_res) begin
          $error("empty_res: expected %0d, got %0d", want.empty_res, out_empty_res);
          n_err++;
        end
        if (out_full_res !== want.full_res) begin
          $error("full_res: expected %0d, got %0d", want.full_res, out_full_res);
          n_err++;
        end
      end
    end
  end

  initial begin
    #6ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/slt_pkg.sv
hw/rtl/slt_ram.sv
hw/rtl/slt_engine.sv
hw/rtl/sorted_list_table.sv
verif/tb_top.sv
